// ----- rtl/day_color_keyframe_interpolator_core_defines.svh -----
// Assertion macros used by the day color interpolator controller.
`ifndef DAY_COLOR_KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH
`define DAY_COLOR_KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DCKI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DCKI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/dcki_pkg.sv -----
// Package with types, constants and the keyframe table of the interpolator.
package dcki_pkg;
  localparam int NUM_KEYFRAMES = 19;
  localparam int SECONDS_PER_DAY = 86400;
  localparam int HALF_HOUR = SECONDS_PER_DAY / 48;
  localparam int LATE_TIME = int'((64'(SECONDS_PER_DAY) * 2399) / 2400);
  localparam int TW = 17;
  localparam int LW = 5;
  localparam int DW = 18;
  localparam int CW = 8;
  localparam int NREG = 4;
  localparam int IW = $clog2(NUM_KEYFRAMES);

  typedef logic [TW-1:0] time_t;
  typedef logic [LW-1:0] label_t;
  typedef logic [IW-1:0] idx_t;

  typedef enum logic [2:0] {
    BASE_ZERO, BASE_SUNRISE, BASE_NOON, BASE_SUNSET, BASE_DUSK, BASE_LATE
  } base_t;

  typedef enum logic [1:0] {
    REG_SUNRISE = 2'd0, REG_SUNSET = 2'd1, REG_NOON = 2'd2, REG_DUSK = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_BUILD, ST_IDLE, ST_SCAN, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic build_start;
    logic build_step;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic build_last;
    logic scan_hit;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    base_t base;
    logic signed [3:0] halves;
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
  } key_def_t;

  function automatic key_def_t key_def(input label_t i);
    key_def_t d;
    case (i)
      5'd0: d = '{BASE_ZERO, 4'sd0, 8'd8, 8'd8, 8'd25};
      5'd1: d = '{BASE_SUNRISE, -4'sd6, 8'd15, 8'd10, 8'd35};
      5'd2: d = '{BASE_SUNRISE, -4'sd2, 8'd25, 8'd15, 8'd45};
      5'd3: d = '{BASE_SUNRISE, -4'sd1, 8'd60, 8'd30, 8'd80};
      5'd4: d = '{BASE_SUNRISE, 4'sd0, 8'd255, 8'd229, 8'd204};
      5'd5: d = '{BASE_SUNRISE, 4'sd1, 8'd255, 8'd218, 8'd185};
      5'd6: d = '{BASE_SUNRISE, 4'sd4, 8'd230, 8'd255, 8'd230};
      5'd7: d = '{BASE_NOON, -4'sd2, 8'd215, 8'd255, 8'd215};
      5'd8: d = '{BASE_NOON, 4'sd0, 8'd135, 8'd206, 8'd250};
      5'd9: d = '{BASE_NOON, 4'sd2, 8'd173, 8'd216, 8'd230};
      5'd10: d = '{BASE_SUNSET, -4'sd4, 8'd210, 8'd180, 8'd140};
      5'd11: d = '{BASE_SUNSET, -4'sd1, 8'd255, 8'd165, 8'd0};
      5'd12: d = '{BASE_SUNSET, 4'sd0, 8'd255, 8'd140, 8'd0};
      5'd13: d = '{BASE_SUNSET, 4'sd1, 8'd200, 8'd80, 8'd60};
      5'd14: d = '{BASE_DUSK, 4'sd0, 8'd72, 8'd61, 8'd85};
      5'd15: d = '{BASE_DUSK, 4'sd2, 8'd65, 8'd55, 8'd80};
      5'd16: d = '{BASE_DUSK, 4'sd4, 8'd45, 8'd25, 8'd65};
      5'd17: d = '{BASE_DUSK, 4'sd6, 8'd25, 8'd15, 8'd45};
      5'd18: d = '{BASE_LATE, 4'sd0, 8'd8, 8'd8, 8'd25};
      default: d = '{BASE_ZERO, 4'sd0, 8'd0, 8'd0, 8'd0};
    endcase
    return d;
  endfunction

  // Reduce a 17-bit value below one day with one compare and subtract.
  function automatic time_t mod_day(input time_t v);
    return (v >= time_t'(SECONDS_PER_DAY)) ? time_t'(v - time_t'(SECONDS_PER_DAY)) : v;
  endfunction
endpackage

// ----- rtl/dcki_if.sv -----
// Valid/ready channel interfaces for queries and results.
interface dcki_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [16:0] time_of_day;
  modport source (output valid, time_of_day, input ready);
  modport sink (input valid, time_of_day, output ready);
endinterface

interface dcki_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [4:0] period_label;
  modport source (output valid, red, green, blue, period_label, input ready);
  modport sink (input valid, red, green, blue, period_label, output ready);
endinterface

// ----- rtl/dcki_ctrl.sv -----
// Controller state machine: sequences keyframe sort, segment scan and divide.
module dcki_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_change,
  input  logic in_fire,
  input  logic out_fire,
  input  dcki_pkg::dp_stat_t stat,
  output dcki_pkg::dp_cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);
  import dcki_pkg::*;
  `include "day_color_keyframe_interpolator_core_defines.svh"

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  // State and pending-rebuild registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BUILD;
      pend_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r | cfg_change;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_BUILD: begin
        if (pend_r) begin
          cmd.build_start = 1'b1;
          pend_nxt = cfg_change;
        end else begin
          cmd.build_step = 1'b1;
          if (stat.build_last) state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pend_r) begin
          state_nxt = ST_BUILD;
        end else begin
          in_ready = 1'b1;
          if (in_fire) begin
            cmd.scan_start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_BUILD;
    endcase
  end

  `DCKI_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE && !pend_r, "ready outside idle")
  `DCKI_ASSERT_NXT(a_fire_scan, clk, rst_n, in_fire, state_r == ST_SCAN, "accepted beat did not start scan")
  `DCKI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_fire, out_valid, "result dropped before taken")
endmodule

// ----- rtl/dcki_dp.sv -----
// Datapath: config registers, insertion-sorted keyframes, scan and serial divider.
module dcki_dp (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [16:0] cfg_data,
  input  logic [16:0] in_time,
  input  dcki_pkg::dp_cmd_t cmd,
  output dcki_pkg::dp_stat_t stat,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [4:0] label
);
  import dcki_pkg::*;

  localparam int NUMW = DW + CW + 1;

  time_t  regs_r [NREG];
  time_t  kt_r [NUM_KEYFRAMES];
  label_t kl_r [NUM_KEYFRAMES];
  label_t bi_r;
  idx_t   si_r;
  time_t  q_r;
  label_t la_r, lb_r;
  logic [DW-1:0] num_r, den_r;
  logic [NUMW-1:0] acc_r [3];
  logic [NUMW-1:0] rem_r [3];
  logic [CW-1:0] quo_r [3];
  logic [4:0] dcnt_r;
  logic [CW-1:0] res_r [3];
  label_t lab_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_SUNRISE] <= TW'(25920);
      regs_r[REG_SUNSET]  <= TW'(61560);
      regs_r[REG_NOON]    <= TW'(43740);
      regs_r[REG_DUSK]    <= TW'(63360);
    end else if (cfg_we) begin
      regs_r[cfg_idx] <= cfg_data;
    end
  end

  // Time of the keyframe being inserted.
  key_def_t d;
  time_t base, newt;
  logic [TW:0] sum;
  always_comb begin
    d = key_def(bi_r);
    case (d.base)
      BASE_SUNRISE: base = mod_day(regs_r[REG_SUNRISE]);
      BASE_NOON:    base = mod_day(regs_r[REG_NOON]);
      BASE_SUNSET:  base = mod_day(regs_r[REG_SUNSET]);
      BASE_DUSK:    base = mod_day(regs_r[REG_DUSK]);
      default:      base = '0;
    endcase
    sum = (TW+1)'(base) + (TW+1)'(SECONDS_PER_DAY)
        + (TW+1)'($signed(d.halves) * HALF_HOUR);
    if (sum >= (TW+1)'(2 * SECONDS_PER_DAY)) newt = TW'(sum - (TW+1)'(2 * SECONDS_PER_DAY));
    else if (sum >= (TW+1)'(SECONDS_PER_DAY)) newt = TW'(sum - (TW+1)'(SECONDS_PER_DAY));
    else newt = TW'(sum);
    if (d.base == BASE_LATE) newt = TW'(LATE_TIME % SECONDS_PER_DAY);
    else if (d.base == BASE_ZERO) newt = '0;
  end

  // One insertion per cycle: entries above the new time shift up in parallel.
  assign stat.build_last = (bi_r == LW'(NUM_KEYFRAMES - 1));
  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      bi_r <= '0;
    end else if (cmd.build_step) begin
      for (int j = 0; j < NUM_KEYFRAMES; j++) begin
        if (j < int'(bi_r)) begin
          if (kt_r[j] > newt) begin
            if (j + 1 < NUM_KEYFRAMES) begin
              kt_r[j+1] <= kt_r[j];
              kl_r[j+1] <= kl_r[j];
            end
          end
        end
        if (j <= int'(bi_r)) begin
          if ((j == 0 || !(kt_r[(j == 0) ? 0 : j-1] > newt))
              && (j == int'(bi_r) || kt_r[j] > newt)) begin
            kt_r[j] <= newt;
            kl_r[j] <= bi_r;
          end
        end
      end
      bi_r <= bi_r + LW'(1);
    end
  end

  // Segment scan, one keyframe pair per cycle.
  idx_t  si1;
  time_t ta, tb;
  logic  last_seg;
  assign si1 = (si_r == idx_t'(NUM_KEYFRAMES - 1)) ? '0 : idx_t'(si_r + idx_t'(1));
  assign ta = kt_r[si_r];
  assign tb = kt_r[si1];
  assign last_seg = (si_r == idx_t'(NUM_KEYFRAMES - 1));
  assign stat.scan_hit = last_seg || (q_r >= ta && q_r <= tb);

  // Color of each endpoint.
  key_def_t da, db;
  assign da = key_def(la_r);
  assign db = key_def(lb_r);

  logic [NUMW-1:0] trial [3];
  always_comb begin
    for (int c = 0; c < 3; c++)
      trial[c] = {rem_r[c][NUMW-2:0], acc_r[c][NUMW-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      q_r  <= mod_day(in_time);
      si_r <= '0;
    end else if (cmd.scan_step) begin
      if (stat.scan_hit) begin
        la_r <= kl_r[si_r];
        lb_r <= kl_r[si1];
        lab_r <= kl_r[si_r];
        if (last_seg) begin
          num_r <= DW'(q_r) - DW'(ta);
          den_r <= DW'(tb) + DW'(SECONDS_PER_DAY) - DW'(ta);
        end else begin
          num_r <= DW'(q_r - ta);
          den_r <= DW'(tb - ta);
        end
      end else begin
        si_r <= si1;
      end
    end
    // Restoring divide: numerators formed, then one quotient bit a cycle.
    if (cmd.div_start) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (dcnt_r == 5'd0) begin
        acc_r[0] <= NUMW'(da.r * (den_r - num_r)) + NUMW'(db.r * num_r);
        acc_r[1] <= NUMW'(da.g * (den_r - num_r)) + NUMW'(db.g * num_r);
        acc_r[2] <= NUMW'(da.b * (den_r - num_r)) + NUMW'(db.b * num_r);
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= '0;
          quo_r[c] <= '0;
        end
      end else begin
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= {acc_r[c][NUMW-2:0], 1'b0};
          if (trial[c] >= NUMW'(den_r)) begin
            rem_r[c] <= trial[c] - NUMW'(den_r);
            quo_r[c] <= {quo_r[c][CW-2:0], 1'b1};
          end else begin
            rem_r[c] <= trial[c];
            quo_r[c] <= {quo_r[c][CW-2:0], 1'b0};
          end
        end
      end
      dcnt_r <= dcnt_r + 5'd1;
    end
    if (cmd.out_load) begin
      if (den_r == '0) begin
        res_r[0] <= db.r;
        res_r[1] <= db.g;
        res_r[2] <= db.b;
      end else begin
        for (int c = 0; c < 3; c++) res_r[c] <= quo_r[c];
      end
    end
  end

  // Quotient needs NUMW shifts; the low 8 bits hold the result.
  assign stat.div_done = (dcnt_r == 5'(NUMW + 1));
  assign red   = res_r[0];
  assign green = res_r[1];
  assign blue  = res_r[2];
  assign label = lab_r;
endmodule

// ----- rtl/day_color_keyframe_interpolator_core.sv -----
// Top level: day color keyframe interpolator with controller and datapath.
// A query is scanned for its keyframe segment, then divided, before its result is valid.
// A new query is taken only after the previous result has been accepted on the output.
// After reset, and after each configuration write, the keyframe sort runs
// before the next query beat is taken; reset restores the default solar times.
module day_color_keyframe_interpolator_core (
  input  logic clk,
  input  logic rst_n,
  dcki_in_if.sink in_ch,
  dcki_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [16:0] cfg_data
);
  import dcki_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic in_rdy, out_vld;

  dcki_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_change(cfg_we),
    .in_fire(in_ch.valid && in_rdy), .out_fire(out_vld && out_ch.ready),
    .stat(stat), .cmd(cmd), .in_ready(in_rdy), .out_valid(out_vld)
  );

  dcki_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .in_time(in_ch.time_of_day), .cmd(cmd), .stat(stat),
    .red(out_ch.red), .green(out_ch.green), .blue(out_ch.blue),
    .label(out_ch.period_label)
  );

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld;
endmodule
